>>> rtl/core/njbt_pkg.sv
// Shared types and constants for the join backoff tracker.
package njbt_pkg;

	// Event codes; code 7 has no name and behaves like a poll
	typedef enum logic [2:0] {
		OP_SET_STATE  = 3'd0,
		OP_TICK       = 3'd1,
		OP_COLLISION  = 3'd2,
		OP_FAILED_JOIN = 3'd3,
		OP_RESET_BACKOFF = 3'd4,
		OP_KEEP_ALIVE = 3'd5,
		OP_POLL       = 3'd6
	} op_t;

	// Association states; codes 5 to 7 are not states
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_SCANNING = 3'd1,
		ST_SYNCED   = 3'd2,
		ST_JOINING  = 3'd3,
		ST_JOINED   = 3'd4
	} assoc_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_GATEWAY_LOSS = 2'd0;
	localparam logic [1:0] CFG_JOIN_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_MIN_EXP      = 2'd2;
	localparam logic [1:0] CFG_MAX_EXP      = 2'd3;

	// Configuration reset values
	localparam logic [31:0] GATEWAY_LOSS_RESET = 32'd1000;
	localparam logic [31:0] JOIN_TIMEOUT_RESET = 32'd5000000;
	localparam logic [3:0]  MIN_EXP_RESET      = 4'd5;
	localparam logic [3:0]  MAX_EXP_RESET      = 4'd9;

	// Largest value the backoff countdown can hold
	localparam logic [8:0] COUNT_MAX = 9'd511;

	typedef struct packed {
		logic [31:0] gateway_loss_slots;
		logic [31:0] join_timeout_ticks;
		logic [3:0]  min_exponent;
		logic [3:0]  max_exponent;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [2:0]  new_state;
		logic [31:0] slot_number;
		logic [31:0] now_time;
		logic [31:0] synced_time;
		logic [15:0] random_word;
	} item_t;

	typedef struct packed {
		logic [2:0] join_state;
		logic       is_joined;
		logic       ready_to_join;
		logic       gateway_lost;
		logic       join_timed_out;
		logic [8:0] backoff_slots_left;
	} result_t;

endpackage

>>> rtl/core/njbt_cfg_regs.sv
// Configuration register file for the join backoff tracker.
module njbt_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output njbt_pkg::cfg_t    cfg
);

	njbt_pkg::cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gateway_loss_slots <= njbt_pkg::GATEWAY_LOSS_RESET;
			cfg_q.join_timeout_ticks <= njbt_pkg::JOIN_TIMEOUT_RESET;
			cfg_q.min_exponent       <= njbt_pkg::MIN_EXP_RESET;
			cfg_q.max_exponent       <= njbt_pkg::MAX_EXP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				njbt_pkg::CFG_GATEWAY_LOSS: cfg_q.gateway_loss_slots <= cfg_data;
				njbt_pkg::CFG_JOIN_TIMEOUT: cfg_q.join_timeout_ticks <= cfg_data;
				njbt_pkg::CFG_MIN_EXP:      cfg_q.min_exponent       <= cfg_data[3:0];
				njbt_pkg::CFG_MAX_EXP:      cfg_q.max_exponent       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/njbt_tracker.sv
// Association state, backoff state and the per-event update and flag logic.
module njbt_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  njbt_pkg::item_t     item,
	input  njbt_pkg::cfg_t      cfg,
	output njbt_pkg::result_t   result
);

	njbt_pkg::assoc_t state_q, state_nxt;
	logic             started_q, started_nxt;
	logic [3:0]       exp_q, exp_nxt;
	logic [8:0]       count_q, count_nxt;
	logic [31:0]      gw_slot_q, gw_slot_nxt;

	logic [4:0]       exp_inc;
	logic [3:0]       exp_coll;
	logic [15:0]      mask;
	logic [15:0]      masked;
	logic [8:0]       count_coll;
	logic [31:0]      slot_dist;
	logic [31:0]      time_dist;

	// Work out the exponent and countdown a collision would give
	always_comb begin
		exp_inc = {1'b0, exp_q} + 5'd1;
		if (!started_q) begin
			exp_coll = cfg.min_exponent;
		end else if (exp_inc < {1'b0, cfg.max_exponent}) begin
			exp_coll = exp_inc[3:0];
		end else begin
			exp_coll = cfg.max_exponent;
		end
		mask   = 16'((17'd1 << exp_coll) - 17'd1);
		masked = item.random_word & mask;
		count_coll = (masked > {7'd0, njbt_pkg::COUNT_MAX}) ? njbt_pkg::COUNT_MAX
			: masked[8:0];
	end

	// Decode the event into the next state
	always_comb begin
		state_nxt   = state_q;
		started_nxt = started_q;
		exp_nxt     = exp_q;
		count_nxt   = count_q;
		gw_slot_nxt = gw_slot_q;
		case (njbt_pkg::op_t'(item.operation))
			njbt_pkg::OP_SET_STATE: begin
				if (item.new_state <= njbt_pkg::ST_JOINED) begin
					state_nxt = njbt_pkg::assoc_t'(item.new_state);
				end
			end
			njbt_pkg::OP_TICK: begin
				if (count_q != 9'd0) begin
					count_nxt = count_q - 9'd1;
				end
			end
			njbt_pkg::OP_COLLISION: begin
				started_nxt = 1'b1;
				exp_nxt     = exp_coll;
				count_nxt   = count_coll;
			end
			njbt_pkg::OP_FAILED_JOIN: begin
				started_nxt = 1'b1;
				exp_nxt     = exp_coll;
				count_nxt   = count_coll;
				state_nxt   = njbt_pkg::ST_SYNCED;
			end
			njbt_pkg::OP_RESET_BACKOFF: begin
				started_nxt = 1'b0;
				exp_nxt     = 4'd0;
				count_nxt   = 9'd0;
			end
			njbt_pkg::OP_KEEP_ALIVE: begin
				gw_slot_nxt = item.slot_number;
			end
			default: ;
		endcase
	end

	// Derive the flags from the state after the event
	always_comb begin
		slot_dist = item.slot_number - gw_slot_nxt;
		time_dist = item.now_time - item.synced_time;
		result.join_state    = state_nxt;
		result.is_joined     = (state_nxt == njbt_pkg::ST_JOINED);
		result.ready_to_join = (state_nxt == njbt_pkg::ST_SYNCED) && (count_nxt == 9'd0);
		result.gateway_lost  = (state_nxt == njbt_pkg::ST_JOINED)
			&& (slot_dist > cfg.gateway_loss_slots);
		result.join_timed_out = ((state_nxt == njbt_pkg::ST_SYNCED)
			|| (state_nxt == njbt_pkg::ST_JOINING))
			&& (time_dist > cfg.join_timeout_ticks);
		result.backoff_slots_left = count_nxt;
	end

	// Commit the update when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= njbt_pkg::ST_IDLE;
			started_q <= 1'b0;
			exp_q     <= 4'd0;
			count_q   <= 9'd0;
			gw_slot_q <= 32'd0;
		end else if (advance) begin
			state_q   <= state_nxt;
			started_q <= started_nxt;
			exp_q     <= exp_nxt;
			count_q   <= count_nxt;
			gw_slot_q <= gw_slot_nxt;
		end
	end

endmodule

>>> rtl/core/node_join_backoff_tracker_core.sv
// Join backoff tracker: input register, event update and result register.
// The tracker takes one event item per clock cycle while item_stall is low and gives one result
// item for each: the item is held in an input register, the state update and flag compares run
// as one pass of logic, and the result lands in an output register, from which it is presented as valid.
// A stall on the result side holds the output register and, through it, the input register;
// a new item is still taken while a finished result waits, as long as the input register
// is empty. Configuration writes are always ready and take effect on the next cycle.
module node_join_backoff_tracker_core (
	input  logic        clk,
	input  logic        arst_n,
	// event channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  operation,
	input  logic [2:0]  new_state,
	input  logic [31:0] slot_number,
	input  logic [31:0] now_time,
	input  logic [31:0] synced_time,
	input  logic [15:0] random_word,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  join_state,
	output logic        is_joined,
	output logic        ready_to_join,
	output logic        gateway_lost,
	output logic        join_timed_out,
	output logic [8:0]  backoff_slots_left,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	njbt_pkg::cfg_t    cfg;
	njbt_pkg::item_t   item_s1;
	logic              valid_s1;
	njbt_pkg::result_t result_nxt;
	njbt_pkg::result_t result_s2;
	logic              valid_s2;
	logic              s2_free;
	logic              advance;
	logic              take_item;

	assign cfg_ready = 1'b1;

	njbt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake between the two register stages
	assign s2_free    = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && s2_free;
	assign item_stall = valid_s1 && !s2_free;
	assign take_item  = item_valid && !item_stall;

	// Hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s2_free) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			item_s1.operation   <= operation;
			item_s1.new_state   <= new_state;
			item_s1.slot_number <= slot_number;
			item_s1.now_time    <= now_time;
			item_s1.synced_time <= synced_time;
			item_s1.random_word <= random_word;
		end
	end

	njbt_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_nxt)
	);

	// Capture the result and hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign result_valid       = valid_s2;
	assign join_state         = result_s2.join_state;
	assign is_joined          = result_s2.is_joined;
	assign ready_to_join      = result_s2.ready_to_join;
	assign gateway_lost       = result_s2.gateway_lost;
	assign join_timed_out     = result_s2.join_timed_out;
	assign backoff_slots_left = result_s2.backoff_slots_left;

	// An accepted item is in the input register on the next cycle
	a_item_lands: assert property (@(posedge clk) disable iff (!arst_n)
		take_item |=> valid_s1)
		else $error("accepted item missing from input register");

	// A stalled result is not overwritten by a moving item
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_stall) |-> !advance)
		else $error("result register overwritten while stalled");

	// Ready to join only in the synced state with the countdown run out
	a_ready_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && ready_to_join) |->
			(join_state == njbt_pkg::ST_SYNCED && backoff_slots_left == 9'd0))
		else $error("ready_to_join inconsistent with state or countdown");

	// Gateway loss is only reported when joined
	a_lost_joined: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && gateway_lost) |-> (is_joined && join_state == njbt_pkg::ST_JOINED))
		else $error("gateway_lost reported outside the joined state");

endmodule
